>>> rtl/csx_pkg.sv
// csx_pkg: shared constants, types and helpers for the canonical skip-mer extractor
// used by csx_lane and canonical_skipmer_extractor_unit; no dependencies
`default_nettype none

package csx_pkg;

  localparam int MAX_PHASES = 16;
  localparam int PHASE_W    = 4;   // bits to index a phase
  localparam int MAX_BASES  = 31;
  localparam int WORD_W     = 62;  // two bits per base
  localparam int IDX_W      = 40;
  localparam int POS_W      = 48;
  localparam int CNT_W      = 5;   // holds 0..MAX_PHASES and raw 5-bit registers
  localparam int SPAN_W     = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // register reset values
  localparam logic [CNT_W-1:0]  RST_USED  = 5'd2;
  localparam logic [CNT_W-1:0]  RST_CYCLE = 5'd3;
  localparam logic [CNT_W-1:0]  RST_BASES = 5'd30;
  localparam logic [SPAN_W-1:0] RST_SPAN  = 10'd44;

  localparam logic [7:0] CHAR_A_UP = 8'h41;
  localparam logic [7:0] CHAR_C_UP = 8'h43;
  localparam logic [7:0] CHAR_G_UP = 8'h47;
  localparam logic [7:0] CHAR_T_UP = 8'h54;
  localparam logic [7:0] CHAR_A_LO = 8'h61;
  localparam logic [7:0] CHAR_C_LO = 8'h63;
  localparam logic [7:0] CHAR_G_LO = 8'h67;
  localparam logic [7:0] CHAR_T_LO = 8'h74;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USED_PER_CYCLE = 2'd0,
    CFG_CYCLE_LENGTH   = 2'd1,
    CFG_WORD_BASES     = 2'd2,
    CFG_SPAN           = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] code;
    logic       unknown;
  } base_code_t;

  // control and shared data broadcast to every lane
  typedef struct packed {
    logic              step;
    logic              restart;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  m;
    logic [1:0]        code;
    logic              unknown;
    logic [IDX_W-1:0]  p;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] rev_ins;
  } lane_ctl_t;

  // next state of one lane
  typedef struct packed {
    logic [WORD_W-1:0] fwd;
    logic [WORD_W-1:0] rev;
    logic              unk_seen;
    logic [IDX_W-1:0]  unk_pos;
  } lane_state_t;

  function automatic base_code_t base_code(input logic [7:0] ch);
    base_code_t r;
    r.code    = CODE_A;
    r.unknown = 1'b0;
    case (ch)
      CHAR_A_UP, CHAR_A_LO: r.code = CODE_A;
      CHAR_C_UP, CHAR_C_LO: r.code = CODE_C;
      CHAR_G_UP, CHAR_G_LO: r.code = CODE_G;
      CHAR_T_UP, CHAR_T_LO: r.code = CODE_T;
      default:              r.unknown = 1'b1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/csx_lane.sv
// csx_lane: state of one skip-mer phase (forward and reverse words, last unknown, counter)
// depends on csx_pkg
`default_nettype none

module csx_lane
  import csx_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [PHASE_W-1:0]   lane_idx_i,
  input  wire lane_ctl_t            ctl_i,
  output      lane_state_t          nxt_o
);

  logic [PHASE_W-1:0] cnt_q, cnt_d;
  lane_state_t        st_q, st_d;

  logic               active;
  logic [PHASE_W-1:0] cnt_base;
  logic [CNT_W-1:0]   cnt_init;
  logic [CNT_W-1:0]   cnt_inc;
  lane_state_t        st_base;
  logic [CNT_W-1:0]   rst_cnt;

  // counter value after reset, with the reset cycle length
  assign rst_cnt = ({1'b0, lane_idx_i} < RST_CYCLE)
                   ? CNT_W'(RST_CYCLE - {1'b0, lane_idx_i} - 5'd1) : '0;

  assign active   = {1'b0, lane_idx_i} < ctl_i.n;
  assign cnt_init = active ? CNT_W'(ctl_i.n - {1'b0, lane_idx_i} - 5'd1) : '0;

  always_comb begin
    cnt_base = ctl_i.restart ? cnt_init[PHASE_W-1:0] : cnt_q;
    if (ctl_i.restart) begin
      st_base = '0;
    end else begin
      st_base = st_q;
    end
    cnt_d = cnt_base;
    st_d  = st_base;
    cnt_inc = {1'b0, cnt_base} + 5'd1;
    if (active) begin
      if (cnt_inc >= ctl_i.n) begin
        cnt_inc = '0;
      end
      cnt_d = cnt_inc[PHASE_W-1:0];
      if (cnt_inc < ctl_i.m) begin
        st_d.fwd = {st_base.fwd[WORD_W-3:0], ctl_i.code} & ctl_i.mask;
        st_d.rev = {2'b00, st_base.rev[WORD_W-1:2]} | ctl_i.rev_ins;
        if (ctl_i.unknown) begin
          st_d.unk_seen = 1'b1;
          st_d.unk_pos  = ctl_i.p;
        end
      end
    end
  end

  assign nxt_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= rst_cnt[PHASE_W-1:0];
      st_q  <= '0;
    end else if (ctl_i.step) begin
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/canonical_skipmer_extractor_unit.sv
// canonical_skipmer_extractor_unit: top level of the canonical skip-mer extractor
// depends on csx_pkg and csx_lane
//
// usage: one ASCII base per input word on the in_valid_i / in_ready_o channel, with
// first_of_sequence_i set on the first base of each sequence (seq_offset_i is taken
// then). every phase lane updates in parallel, so a base is accepted every cycle while
// results are taken. an input register feeds one pass of logic that updates the lanes
// and picks the examined phase; a result register drives skipmer_word_o, position_o and
// reversed_o on the out_valid_o / out_ready_i channel. a base yields zero or one result
// word, which the result register holds until it is taken.
// throughput: one base per cycle while results are taken.
// stall: while a result waits, the input register still fills; after that the input
// side holds off until the result is taken, and no word is dropped.
// reset: all lanes cleared, cycle counters set for a cycle of three, registers to
// their defaults (m=2, n=3, k=30, span=44); a first-of-sequence base re-arms the
// lanes with the current cycle length. configuration writes via cfg_we_i are taken
// at once and are meant for idle periods.
`default_nettype none

module canonical_skipmer_extractor_unit
  import csx_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [7:0]            base_char_i,
  input  wire logic                  first_of_sequence_i,
  input  wire logic [POS_W-1:0]      seq_offset_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [WORD_W-1:0]     skipmer_word_o,
  output      logic [POS_W-1:0]      position_o,
  output      logic                  reversed_o
);

  // configuration
  logic [CNT_W-1:0]  used_q, cycle_q, bases_q;
  logic [SPAN_W-1:0] span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= RST_USED;
      cycle_q <= RST_CYCLE;
      bases_q <= RST_BASES;
      span_q  <= RST_SPAN;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_USED_PER_CYCLE: used_q  <= cfg_data_i[CNT_W-1:0];
        CFG_CYCLE_LENGTH:   cycle_q <= cfg_data_i[CNT_W-1:0];
        CFG_WORD_BASES:     bases_q <= cfg_data_i[CNT_W-1:0];
        CFG_SPAN:           span_q  <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  logic [CNT_W-1:0]  n_eff, k_eff;
  logic [SPAN_W-1:0] s_eff;

  always_comb begin
    if (cycle_q == '0) begin
      n_eff = 5'd1;
    end else if (cycle_q > CNT_W'(MAX_PHASES)) begin
      n_eff = CNT_W'(MAX_PHASES);
    end else begin
      n_eff = cycle_q;
    end
    if (bases_q == '0) begin
      k_eff = 5'd1;
    end else if (bases_q > CNT_W'(MAX_BASES)) begin
      k_eff = CNT_W'(MAX_BASES);
    end else begin
      k_eff = bases_q;
    end
    s_eff = (span_q == '0) ? 10'd1 : span_q;
  end

  // input register
  logic             s1_valid_q;
  logic [7:0]       s1_char_q;
  logic             s1_first_q;
  logic [POS_W-1:0] s1_offset_q;

  logic advance, step;

  assign advance    = !out_valid_o || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q   <= base_char_i;
      s1_first_q  <= first_of_sequence_i;
      s1_offset_q <= seq_offset_i;
    end
  end

  // sequence state
  logic [IDX_W-1:0]   base_idx_q, base_idx_d;
  logic [POS_W-1:0]   cur_off_q, cur_off_d;
  logic [PHASE_W-1:0] emit_q, emit_d;

  base_code_t         bc;
  lane_ctl_t          ctl;
  lane_state_t        lane_nx [MAX_PHASES];
  lane_state_t        sel;
  logic [IDX_W-1:0]   p;
  logic [IDX_W:0]     p_inc;
  logic [PHASE_W:0]   f;
  logic [PHASE_W-1:0] e_new;
  logic               before_span;
  logic               blocked;
  logic               emit;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   pos;
  logic               use_rev;

  assign bc = base_code(s1_char_q);
  assign p  = s1_first_q ? '0 : base_idx_q;

  always_comb begin
    ctl.step    = step;
    ctl.restart = s1_first_q;
    ctl.n       = n_eff;
    ctl.m       = used_q;
    ctl.code    = bc.code;
    ctl.unknown = bc.unknown;
    ctl.p       = p;
    ctl.mask    = ~({WORD_W{1'b1}} << {k_eff, 1'b0});
    ctl.rev_ins = WORD_W'(CODE_T - bc.code) << {k_eff - 5'd1, 1'b0};
  end

  for (genvar g = 0; g < MAX_PHASES; g++) begin : g_lane
    csx_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .lane_idx_i (PHASE_W'(g)),
      .ctl_i      (ctl),
      .nxt_o      (lane_nx[g])
    );
  end

  always_comb begin
    p_inc       = {1'b0, p} + {{IDX_W{1'b0}}, 1'b1};
    before_span = p_inc < {{(IDX_W+1-SPAN_W){1'b0}}, s_eff};
    base_idx_d  = (p == IDX_MAX) ? p : p_inc[IDX_W-1:0];
    cur_off_d   = s1_first_q ? s1_offset_q : cur_off_q;

    // next examined phase, rotating once the first span is complete
    f = {1'b0, (s1_first_q ? {PHASE_W{1'b0}} : emit_q)} + {{PHASE_W{1'b0}}, 1'b1};
    if (p_inc == {{(IDX_W+1-SPAN_W){1'b0}}, s_eff}) begin
      e_new = '0;
    end else if (f >= {1'b0, n_eff}) begin
      e_new = '0;
    end else begin
      e_new = f[PHASE_W-1:0];
    end
    emit_d = before_span ? (s1_first_q ? '0 : emit_q) : e_new;

    sel     = lane_nx[e_new];
    blocked = sel.unk_seen &&
              (({1'b0, sel.unk_pos} + {{(IDX_W+1-SPAN_W){1'b0}}, s_eff}) > {1'b0, p});
    emit    = !before_span && !blocked;

    pos_sum = {1'b0, cur_off_d} + {{(POS_W+1-IDX_W){1'b0}}, p};
    pos     = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
    use_rev = sel.fwd > sel.rev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_idx_q <= '0;
      cur_off_q  <= '0;
      emit_q     <= '0;
    end else if (step) begin
      base_idx_q <= base_idx_d;
      cur_off_q  <= cur_off_d;
      emit_q     <= emit_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      skipmer_word_o <= use_rev ? sel.rev : sel.fwd;
      position_o     <= pos;
      reversed_o     <= use_rev;
    end
  end

endmodule

`default_nettype wire
